[hdl/srox_pkg.sv]
// Shared types and constants of the shift register output expander.
`timescale 1ns / 1ps

package srox_pkg;

   // working width of the pin image: the 6-bit index reaches at most 64 pins
   localparam int WORK_W     = 64;
   localparam int SHAMT_W    = 6;
   localparam int MODE_W     = 4;
   localparam int INDEX_W    = 6;
   localparam int VALUE_W    = 32;
   localparam int COUNT_W    = 6;
   localparam int CHIP_CNT_W = 4;
   localparam int STATUS_W   = 2;
   localparam int BYTE_W     = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // command codes
   localparam logic [MODE_W-1:0] MODE_INIT      = 4'd0;
   localparam logic [MODE_W-1:0] MODE_SET_PIN   = 4'd1;
   localparam logic [MODE_W-1:0] MODE_GET_PIN   = 4'd2;
   localparam logic [MODE_W-1:0] MODE_TOGGLE    = 4'd3;
   localparam logic [MODE_W-1:0] MODE_SET_CHIP  = 4'd4;
   localparam logic [MODE_W-1:0] MODE_GET_CHIP  = 4'd5;
   localparam logic [MODE_W-1:0] MODE_WRITE_RUN = 4'd6;
   localparam logic [MODE_W-1:0] MODE_READ_RUN  = 4'd7;
   localparam logic [MODE_W-1:0] MODE_UPDATE    = 4'd8;
   localparam logic [MODE_W-1:0] MODE_CLEAR     = 4'd9;
   localparam logic [MODE_W-1:0] MODE_ENABLE    = 4'd10;
   localparam logic [MODE_W-1:0] MODE_DISABLE   = 4'd11;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_INIT  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;

   // register index, taken from paddr bit 2
   localparam logic CSR_IDX_CHAIN = 1'b0;
   localparam logic CSR_IDX_OE    = 1'b1;

   localparam logic [WORK_W-1:0] ALL_ONES = '1;

   typedef enum logic [2:0] {
      K_REPLY,
      K_WRITE,
      K_TOGGLE,
      K_READ,
      K_UPDATE
   } kind_type;

   typedef enum logic [1:0] {
      EN_KEEP,
      EN_ON,
      EN_OFF
   } en_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_EMIT
   } back_state_type;

   // decoded command handed from front to back
   typedef struct packed {
      kind_type                kind;
      logic [STATUS_W-1:0]     status;
      logic [WORK_W-1:0]       mask;
      logic [WORK_W-1:0]       data;
      logic [SHAMT_W-1:0]      shamt;
      en_op_type               en_op;
      logic [CHIP_CNT_W-1:0]   chips;
   } cmd_type;

endpackage

[hdl/srox_front.sv]
// Command front end: accepts requests, checks them and turns them into masked image operations.
`timescale 1ns / 1ps

module srox_front import srox_pkg::*; #(
   parameter int MAX_CHAIN = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic [INDEX_W-1:0]    req_index,
   input  logic [VALUE_W-1:0]    req_value,
   input  logic [COUNT_W-1:0]    req_bit_count,
   input  logic [CHIP_CNT_W-1:0] chain_length,
   input  logic                  oe_present,
   input  logic                  q_full,
   output logic                  q_push,
   output cmd_type               q_cmd
);

   logic                  ready_flag_ff;
   logic                  ready_flag_in;
   logic [CHIP_CNT_W-1:0] chips;
   logic [INDEX_W:0]      pins;
   logic [INDEX_W:0]      idx_ext;
   logic [INDEX_W:0]      run_end;
   logic [WORK_W-1:0]     run_mask;
   logic [SHAMT_W-1:0]    chip_shamt;
   logic                  init_ok;

   assign chips      = (chain_length > CHIP_CNT_W'(MAX_CHAIN)) ?
                       CHIP_CNT_W'(MAX_CHAIN) : chain_length;
   assign pins       = {chips, 3'b000};
   assign idx_ext    = {1'b0, req_index};
   assign run_end    = idx_ext + {1'b0, req_bit_count};
   assign run_mask   = (WORK_W'(1) << req_bit_count) - WORK_W'(1);
   assign chip_shamt = {req_index[2:0], 3'b000};

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_cmd        = '0;
      q_cmd.kind   = K_REPLY;
      q_cmd.status = STATUS_OK;
      q_cmd.en_op  = EN_KEEP;
      q_cmd.chips  = chips;
      init_ok      = 1'b0;

      if (req_mode > MODE_DISABLE) begin
         q_cmd.status = STATUS_RANGE;
      end else if (req_mode == MODE_INIT) begin
         if (chain_length == '0 || chain_length > CHIP_CNT_W'(MAX_CHAIN)) begin
            q_cmd.status = STATUS_RANGE;
         end else begin
            q_cmd.kind  = K_UPDATE;
            q_cmd.mask  = ALL_ONES;
            q_cmd.en_op = oe_present ? EN_ON : EN_KEEP;
            init_ok     = 1'b1;
         end
      end else if (!ready_flag_ff) begin
         q_cmd.status = STATUS_NO_INIT;
      end else begin
         unique case (req_mode) inside
            MODE_SET_PIN, MODE_GET_PIN, MODE_TOGGLE: begin
               if (idx_ext >= pins) begin
                  q_cmd.status = STATUS_RANGE;
               end else begin
                  q_cmd.mask  = WORK_W'(1) << req_index;
                  q_cmd.data  = WORK_W'(req_value[0]) << req_index;
                  q_cmd.shamt = req_index;
                  if (req_mode == MODE_SET_PIN) begin
                     q_cmd.kind = K_WRITE;
                  end else if (req_mode == MODE_GET_PIN) begin
                     q_cmd.kind = K_READ;
                  end else begin
                     q_cmd.kind = K_TOGGLE;
                  end
               end
            end
            MODE_SET_CHIP, MODE_GET_CHIP: begin
               if (req_index >= INDEX_W'(chips)) begin
                  q_cmd.status = STATUS_RANGE;
               end else begin
                  q_cmd.mask  = WORK_W'(8'hFF) << chip_shamt;
                  q_cmd.data  = WORK_W'(req_value[7:0]) << chip_shamt;
                  q_cmd.shamt = chip_shamt;
                  q_cmd.kind  = (req_mode == MODE_SET_CHIP) ? K_WRITE : K_READ;
               end
            end
            MODE_WRITE_RUN: begin
               if (run_end > pins) begin
                  q_cmd.status = STATUS_RANGE;
               end else begin
                  // run positions 32 and above take zeros from the upper half
                  q_cmd.kind = K_WRITE;
                  q_cmd.mask = run_mask << req_index;
                  q_cmd.data = WORK_W'(req_value) << req_index;
               end
            end
            MODE_READ_RUN: begin
               if (run_end > pins || req_bit_count > COUNT_W'(VALUE_W)) begin
                  q_cmd.status = STATUS_RANGE;
               end else begin
                  q_cmd.kind  = K_READ;
                  q_cmd.mask  = run_mask << req_index;
                  q_cmd.shamt = req_index;
               end
            end
            MODE_UPDATE: begin
               q_cmd.kind = K_UPDATE;
            end
            MODE_CLEAR: begin
               q_cmd.kind = K_UPDATE;
               q_cmd.mask = (WORK_W'(1) << pins) - WORK_W'(1);
            end
            MODE_ENABLE, MODE_DISABLE: begin
               if (oe_present) begin
                  q_cmd.en_op = (req_mode == MODE_ENABLE) ? EN_ON : EN_OFF;
               end
            end
            default: begin
               q_cmd.status = STATUS_RANGE;
            end
         endcase
      end
   end

   assign ready_flag_in = ready_flag_ff || (q_push && init_ok);

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_flag_ff <= 1'b0;
      end else begin
         ready_flag_ff <= ready_flag_in;
      end
   end

endmodule

[hdl/srox_queue.sv]
// Two-entry command queue between front end and back end.
`timescale 1ns / 1ps

module srox_queue import srox_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head_cmd,
   output logic    full,
   output logic    empty
);

   localparam int DEPTH = 2;

   cmd_type    entry_ff [DEPTH];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign full     = (count_ff == 2'(DEPTH));
   assign empty    = (count_ff == 2'd0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hdl/srox_back.sv]
// Command back end: holds the pin image and enable level, executes commands, drives results.
`timescale 1ns / 1ps

module srox_back import srox_pkg::*; #(
   parameter int MAX_CHAIN = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  cmd_type             q_head,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [VALUE_W-1:0]  rsp_read_value,
   output logic [BYTE_W-1:0]   rsp_shift_byte,
   output logic                rsp_shift_valid,
   output logic                rsp_latch_pulse,
   output logic                rsp_enable_n,
   output logic                rsp_last
);

   localparam int PINS = MAX_CHAIN * 8;
   localparam int CW   = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;

   back_state_type      state_ff;
   back_state_type      state_in;
   cmd_type             cur_ff;
   cmd_type             cur_in;
   logic [PINS-1:0]     image_ff;
   logic [PINS-1:0]     image_in;
   logic                enable_n_ff;
   logic                enable_n_in;
   logic [CW-1:0]       byte_cnt_ff;
   logic [CW-1:0]       byte_cnt_in;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [STATUS_W-1:0] rsp_status_in;
   logic [VALUE_W-1:0]  rsp_read_value_ff;
   logic [VALUE_W-1:0]  rsp_read_value_in;
   logic [BYTE_W-1:0]   rsp_shift_byte_ff;
   logic [BYTE_W-1:0]   rsp_shift_byte_in;
   logic                rsp_shift_valid_ff;
   logic                rsp_shift_valid_in;
   logic                rsp_latch_pulse_ff;
   logic                rsp_latch_pulse_in;
   logic                rsp_enable_n_ff;
   logic                rsp_enable_n_in;
   logic                rsp_last_ff;
   logic                rsp_last_in;

   logic                slot_free;
   logic [WORK_W-1:0]   img_w;
   logic [WORK_W-1:0]   img_next_w;
   logic [WORK_W-1:0]   read_w;
   logic [WORK_W-1:0]   byte_w;
   logic                level_next;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign img_w     = WORK_W'(image_ff);
   assign read_w    = (img_w & cur_ff.mask) >> cur_ff.shamt;
   assign byte_w    = img_w >> {byte_cnt_ff, 3'b000};

   always_comb begin
      case (cur_ff.kind) inside
         K_WRITE, K_UPDATE: img_next_w = (img_w & ~cur_ff.mask) | (cur_ff.data & cur_ff.mask);
         K_TOGGLE:          img_next_w = img_w ^ cur_ff.mask;
         default:           img_next_w = img_w;
      endcase
      case (cur_ff.en_op)
         EN_ON:   level_next = 1'b0;
         EN_OFF:  level_next = 1'b1;
         default: level_next = enable_n_ff;
      endcase
   end

   always_comb begin
      state_in           = state_ff;
      cur_in             = cur_ff;
      image_in           = image_ff;
      enable_n_in        = enable_n_ff;
      byte_cnt_in        = byte_cnt_ff;
      q_pop              = 1'b0;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_status_in      = rsp_status_ff;
      rsp_read_value_in  = rsp_read_value_ff;
      rsp_shift_byte_in  = rsp_shift_byte_ff;
      rsp_shift_valid_in = rsp_shift_valid_ff;
      rsp_latch_pulse_in = rsp_latch_pulse_ff;
      rsp_enable_n_in    = rsp_enable_n_ff;
      rsp_last_in        = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cur_in   = q_head;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // image and enable change only when the command can leave this state
            if (slot_free) begin
               image_in    = img_next_w[PINS-1:0];
               enable_n_in = level_next;
               if (cur_ff.kind == K_UPDATE) begin
                  byte_cnt_in = CW'(cur_ff.chips - CHIP_CNT_W'(1));
                  state_in    = ST_EMIT;
               end else begin
                  rsp_valid_in       = 1'b1;
                  rsp_status_in      = cur_ff.status;
                  rsp_read_value_in  = (cur_ff.kind == K_READ) ? read_w[VALUE_W-1:0] : '0;
                  rsp_shift_byte_in  = '0;
                  rsp_shift_valid_in = 1'b0;
                  rsp_latch_pulse_in = 1'b0;
                  rsp_enable_n_in    = level_next;
                  rsp_last_in        = 1'b1;
                  state_in           = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in      = 1'b1;
               rsp_status_in     = STATUS_OK;
               rsp_read_value_in = '0;
               rsp_enable_n_in   = enable_n_ff;
               if (cur_ff.chips == '0) begin
                  // empty chain: latch only
                  rsp_shift_byte_in  = '0;
                  rsp_shift_valid_in = 1'b0;
                  rsp_latch_pulse_in = 1'b1;
                  rsp_last_in        = 1'b1;
                  state_in           = ST_IDLE;
               end else begin
                  rsp_shift_byte_in  = byte_w[BYTE_W-1:0];
                  rsp_shift_valid_in = 1'b1;
                  rsp_latch_pulse_in = (byte_cnt_ff == '0);
                  rsp_last_in        = (byte_cnt_ff == '0);
                  if (byte_cnt_ff == '0) begin
                     state_in = ST_IDLE;
                  end else begin
                     byte_cnt_in = byte_cnt_ff - CW'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         image_ff     <= '0;
         enable_n_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         image_ff     <= image_in;
         enable_n_ff  <= enable_n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff             <= cur_in;
      byte_cnt_ff        <= byte_cnt_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_read_value_ff  <= rsp_read_value_in;
      rsp_shift_byte_ff  <= rsp_shift_byte_in;
      rsp_shift_valid_ff <= rsp_shift_valid_in;
      rsp_latch_pulse_ff <= rsp_latch_pulse_in;
      rsp_enable_n_ff    <= rsp_enable_n_in;
      rsp_last_ff        <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_shift_byte  = rsp_shift_byte_ff;
   assign rsp_shift_valid = rsp_shift_valid_ff;
   assign rsp_latch_pulse = rsp_latch_pulse_ff;
   assign rsp_enable_n    = rsp_enable_n_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

[hdl/shift_register_output_expander_top.sv]
// Top level of the shift register output expander: register port, front end, queue, back end.
`timescale 1ns / 1ps
//
// Keeps a shadow image of a daisy chain of 8-bit output shift registers.
// req_* carries one command per transfer (mode, index, value, bit_count);
// rsp_* returns its results, one transfer each, the final one with rsp_last.
// An update (also done by init and clear) gives one result per chip in use,
// last chip first, or a single latch-only result on an empty chain; the final
// result carries rsp_latch_pulse. rsp_enable_n is the output enable level.
// csr_* is an APB-style port: chain_length at 0x0, oe_present at 0x4;
// write only while no command is outstanding.
// A single-result command passes the queue and the back end's dequeue and
// execute states before its result is registered; an update then stays in
// the emit state for one result per chip in use. The back end takes the next
// command only after the last result of the one before; the execute and emit
// states wait while the result register is still held by a stalled receiver.
// A two-entry queue decouples the front end, so requests keep being taken
// while a result waits on a stalled receiver; once the queue is full,
// req_ready drops. Results hold while rsp_ready is low.
// Reset: image cleared, not initialised, enable level off (enable_n high),
// chain_length 1, oe_present 0, queue and result register empty.
//
module shift_register_output_expander_top import srox_pkg::*; #(
   parameter int MAX_CHAIN = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic [INDEX_W-1:0]    req_index,
   input  logic [VALUE_W-1:0]    req_value,
   input  logic [COUNT_W-1:0]    req_bit_count,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [VALUE_W-1:0]    rsp_read_value,
   output logic [BYTE_W-1:0]     rsp_shift_byte,
   output logic                  rsp_shift_valid,
   output logic                  rsp_latch_pulse,
   output logic                  rsp_enable_n,
   output logic                  rsp_last,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [CHIP_CNT_W-1:0] chain_length_ff;
   logic [CHIP_CNT_W-1:0] chain_length_in;
   logic                  oe_present_ff;
   logic                  oe_present_in;
   logic                  csr_write;

   logic    q_full;
   logic    q_empty;
   logic    q_push;
   logic    q_pop;
   cmd_type q_cmd;
   cmd_type q_head;

   // register port: single-cycle access, register picked by address bit 2
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      chain_length_in = chain_length_ff;
      oe_present_in   = oe_present_ff;
      if (csr_write) begin
         if (csr_paddr[2] == CSR_IDX_CHAIN) begin
            chain_length_in = csr_pwdata[CHIP_CNT_W-1:0];
         end else begin
            oe_present_in = csr_pwdata[0];
         end
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_IDX_CHAIN: csr_prdata = CSR_DATA_W'(chain_length_ff);
         CSR_IDX_OE:    csr_prdata = CSR_DATA_W'(oe_present_ff);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_length_ff <= CHIP_CNT_W'(1);
         oe_present_ff   <= 1'b0;
      end else begin
         chain_length_ff <= chain_length_in;
         oe_present_ff   <= oe_present_in;
      end
   end

   // front end: range checks and decode into masked image operations
   srox_front #(
      .MAX_CHAIN (MAX_CHAIN)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_index     (req_index),
      .req_value     (req_value),
      .req_bit_count (req_bit_count),
      .chain_length  (chain_length_ff),
      .oe_present    (oe_present_ff),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (q_cmd)
   );

   srox_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .head_cmd (q_head),
      .full     (q_full),
      .empty    (q_empty)
   );

   // back end: image update, read-back and byte streaming
   srox_back #(
      .MAX_CHAIN (MAX_CHAIN)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_shift_byte  (rsp_shift_byte),
      .rsp_shift_valid (rsp_shift_valid),
      .rsp_latch_pulse (rsp_latch_pulse),
      .rsp_enable_n    (rsp_enable_n),
      .rsp_last        (rsp_last)
   );

endmodule

[hdl/srox_checker.sv]
// Port-level checks on the shift register output expander, bound to the top level.
`timescale 1ns / 1ps

module srox_checker import srox_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [STATUS_W-1:0]   rsp_status,
   input logic [VALUE_W-1:0]    rsp_read_value,
   input logic [BYTE_W-1:0]     rsp_shift_byte,
   input logic                  rsp_shift_valid,
   input logic                  rsp_latch_pulse,
   input logic                  rsp_enable_n,
   input logic                  rsp_last
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_read_value) && $stable(rsp_shift_byte) && $stable(rsp_last)
         && $stable(rsp_shift_valid) && $stable(rsp_latch_pulse) && $stable(rsp_enable_n))
      else $error("result changed while stalled");

   // refused commands read nothing and shift nothing
   a_err_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |->
         rsp_read_value == '0 && !rsp_shift_valid && !rsp_latch_pulse && rsp_last)
      else $error("refused command produced data");

   // the latch pulse only comes with the closing transfer of an update
   a_latch_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_latch_pulse |-> rsp_last && rsp_read_value == '0)
      else $error("latch pulse not on final transfer");

   // no shift data without shift_valid
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_shift_valid |-> rsp_shift_byte == '0)
      else $error("shift byte set without shift_valid");

   // nothing is presented straight after reset, and the queue is open
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("result valid or request blocked after reset");

endmodule

bind shift_register_output_expander_top srox_checker u_checker (.*);

[bench/srox_shadow_checker.sv]
// Checker for the shift register output expander: shadow-image predictor and result comparison.
`timescale 1ns / 1ps

module srox_shadow_checker import srox_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic [INDEX_W-1:0]    req_index,
   input  logic [VALUE_W-1:0]    req_value,
   input  logic [COUNT_W-1:0]    req_bit_count,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [STATUS_W-1:0]   rsp_status,
   input  logic [VALUE_W-1:0]    rsp_read_value,
   input  logic [BYTE_W-1:0]     rsp_shift_byte,
   input  logic                  rsp_shift_valid,
   input  logic                  rsp_latch_pulse,
   input  logic                  rsp_enable_n,
   input  logic                  rsp_last,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    fail_count,
   output int                    pending
);

   localparam int CHIP_SLOTS   = 8;
   localparam int RUN_MAX      = 32;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  read_value;
      logic [BYTE_W-1:0]   shift_byte;
      logic                shift_valid;
      logic                latch_pulse;
      logic                enable_n;
      logic                last;
   } reply_type;

   reply_type             expected_replies[$];
   logic [BYTE_W-1:0]     shadow [CHIP_SLOTS];
   logic                  initialised;
   logic                  enable_level;
   logic                  oe_wired;
   logic [CHIP_CNT_W-1:0] chain_len;

   function automatic int chips_used();
      if (chain_len > CHIP_SLOTS) return CHIP_SLOTS;
      return int'(chain_len);
   endfunction

   function automatic logic pin_of(input int p);
      return shadow[p / 8][p % 8];
   endfunction

   task automatic drive_pin(input int p, input logic b);
      shadow[p / 8][p % 8] = b;
   endtask

   task automatic expect_reply(input logic [STATUS_W-1:0] st, input logic [VALUE_W-1:0] rd,
                               input logic [BYTE_W-1:0] sb, input logic sv, input logic lp,
                               input logic fin);
      reply_type r;
      r.status      = st;
      r.read_value  = rd;
      r.shift_byte  = sb;
      r.shift_valid = sv;
      r.latch_pulse = lp;
      r.enable_n    = enable_level;
      r.last        = fin;
      expected_replies.push_back(r);
   endtask

   // image goes out last chip first; latch rides on the final byte
   task automatic expect_stream();
      int n;
      n = chips_used();
      if (n == 0) begin
         expect_reply(STATUS_OK, '0, '0, 1'b0, 1'b1, 1'b1);
      end else begin
         for (int k = 0; k < n; k++)
            expect_reply(STATUS_OK, '0, shadow[n - 1 - k], 1'b1, k == n - 1, k == n - 1);
      end
   endtask

   task automatic execute_command(input logic [MODE_W-1:0] mode, input logic [INDEX_W-1:0] idx,
                                  input logic [VALUE_W-1:0] val,
                                  input logic [COUNT_W-1:0] cnt);
      int               n;
      int               pins;
      int               span;
      logic [VALUE_W-1:0] rd;
      n    = chips_used();
      pins = 8 * n;
      span = int'(idx) + int'(cnt);
      rd   = '0;
      if (mode > MODE_DISABLE) begin
         expect_reply(STATUS_RANGE, '0, '0, 1'b0, 1'b0, 1'b1);
         return;
      end
      if (mode == MODE_INIT) begin
         if (chain_len == 0 || chain_len > CHIP_SLOTS) begin
            expect_reply(STATUS_RANGE, '0, '0, 1'b0, 1'b0, 1'b1);
         end else begin
            for (int k = 0; k < CHIP_SLOTS; k++) shadow[k] = '0;
            initialised = 1'b1;
            if (oe_wired) enable_level = 1'b0;
            expect_stream();
         end
         return;
      end
      if (!initialised) begin
         expect_reply(STATUS_NO_INIT, '0, '0, 1'b0, 1'b0, 1'b1);
         return;
      end
      case (mode) inside
         MODE_SET_PIN, MODE_GET_PIN, MODE_TOGGLE: begin
            if (int'(idx) >= pins) begin
               expect_reply(STATUS_RANGE, '0, '0, 1'b0, 1'b0, 1'b1);
               return;
            end
            if (mode == MODE_SET_PIN) drive_pin(int'(idx), val[0]);
            else if (mode == MODE_GET_PIN) rd[0] = pin_of(int'(idx));
            else drive_pin(int'(idx), !pin_of(int'(idx)));
         end
         MODE_SET_CHIP, MODE_GET_CHIP: begin
            if (int'(idx) >= n) begin
               expect_reply(STATUS_RANGE, '0, '0, 1'b0, 1'b0, 1'b1);
               return;
            end
            if (mode == MODE_SET_CHIP) shadow[idx[2:0]] = val[BYTE_W-1:0];
            else rd[BYTE_W-1:0] = shadow[idx[2:0]];
         end
         MODE_WRITE_RUN: begin
            if (span > pins) begin
               expect_reply(STATUS_RANGE, '0, '0, 1'b0, 1'b0, 1'b1);
               return;
            end
            // run positions 32 and above are written as zero
            for (int i = 0; i < int'(cnt); i++)
               drive_pin(int'(idx) + i, (i < RUN_MAX) ? val[i] : 1'b0);
         end
         MODE_READ_RUN: begin
            if (span > pins || int'(cnt) > RUN_MAX) begin
               expect_reply(STATUS_RANGE, '0, '0, 1'b0, 1'b0, 1'b1);
               return;
            end
            for (int i = 0; i < int'(cnt); i++) rd[i] = pin_of(int'(idx) + i);
         end
         MODE_UPDATE: begin
            expect_stream();
            return;
         end
         MODE_CLEAR: begin
            for (int k = 0; k < n; k++) shadow[k] = '0;
            expect_stream();
            return;
         end
         default: begin
            // enable / disable only move the line when it is wired
            if (oe_wired) enable_level = (mode == MODE_ENABLE) ? 1'b0 : 1'b1;
         end
      endcase
      expect_reply(STATUS_OK, rd, '0, 1'b0, 1'b0, 1'b1);
   endtask

   always @(posedge clock) begin
      reply_type seen;
      reply_type want;
      if (reset) begin
         for (int k = 0; k < CHIP_SLOTS; k++) shadow[k] = '0;
         initialised  = 1'b0;
         enable_level = 1'b1;
         oe_wired     = 1'b0;
         chain_len    = 4'd1;
         fail_count   = 0;
         expected_replies.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == CSR_IDX_CHAIN) chain_len = csr_pwdata[CHIP_CNT_W-1:0];
            else oe_wired = csr_pwdata[0];
         end
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_status, rsp_read_value, rsp_shift_byte, rsp_shift_valid,
                     rsp_latch_pulse, rsp_enable_n, rsp_last};
            if (expected_replies.size() == 0) begin
               if (fail_count < REPORT_LIMIT)
                  $display("%0t: unexpected result st=%0d rd=%h sb=%h sv=%b lp=%b en_n=%b last=%b",
                           $time, seen.status, seen.read_value, seen.shift_byte,
                           seen.shift_valid, seen.latch_pulse, seen.enable_n, seen.last);
               fail_count++;
            end else begin
               want = expected_replies.pop_front();
               if (seen !== want) begin
                  if (fail_count < REPORT_LIMIT) begin
                     $display("%0t: expected st=%0d rd=%h sb=%h sv=%b lp=%b en_n=%b last=%b",
                              $time, want.status, want.read_value, want.shift_byte,
                              want.shift_valid, want.latch_pulse, want.enable_n, want.last);
                     $display("%0t:      got st=%0d rd=%h sb=%h sv=%b lp=%b en_n=%b last=%b",
                              $time, seen.status, seen.read_value, seen.shift_byte,
                              seen.shift_valid, seen.latch_pulse, seen.enable_n, seen.last);
                  end
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            execute_command(req_mode, req_index, req_value, req_bit_count);
      end
      pending <= expected_replies.size();
   end

endmodule

[bench/shift_register_output_expander_top_tb.sv]
// Testbench top for the shift register output expander: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps

module shift_register_output_expander_top_tb import srox_pkg::*; ();

   localparam int PHASES          = 10;
   localparam int RANDOM_PER_PHASE = 34;
   localparam int HOLD_CYCLES     = 300;
   localparam int DRAIN_CYCLES    = 20;
   localparam int CYCLE_LIMIT     = 500000;
   localparam int CHIP_SLOTS      = 8;

   // modes past the last command; must be refused as out of range
   localparam logic [MODE_W-1:0] MODE_BEYOND = MODE_DISABLE + 1'b1;
   localparam logic [MODE_W-1:0] MODE_TOP    = '1;

   localparam logic [CSR_ADDR_W-1:0] ADDR_CHAIN = {CSR_IDX_CHAIN, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_OE    = {CSR_IDX_OE, 2'b00};

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [MODE_W-1:0]     req_mode;
   logic [INDEX_W-1:0]    req_index;
   logic [VALUE_W-1:0]    req_value;
   logic [COUNT_W-1:0]    req_bit_count;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [STATUS_W-1:0]   rsp_status;
   logic [VALUE_W-1:0]    rsp_read_value;
   logic [BYTE_W-1:0]     rsp_shift_byte;
   logic                  rsp_shift_valid;
   logic                  rsp_latch_pulse;
   logic                  rsp_enable_n;
   logic                  rsp_last;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int                    fail_count;
   int                    pending;      // results still owed by the block
   int                    chips_now;    // chips in use as last written, for shaping stimulus
   int unsigned           cycle_count = 0;
   bit                    burst = 1'b0; // no idling on either side while set
   bit                    rsp_hold = 1'b0;

   always #5 clock = ~clock;

   shift_register_output_expander_top u_dut (.*);

   srox_shadow_checker u_checker (.*);

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result sink: random back-pressure per transfer, plus one long hold-off when asked
   initial begin : result_sink
      int gap;
      rsp_ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold) begin
            gap      = HOLD_CYCLES;
            rsp_hold = 1'b0;
         end else begin
            gap = burst ? 0 : $urandom_range(0, 8);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // one command transfer; valid is left high so back-to-back commands need no gap
   task automatic send_cmd(input logic [MODE_W-1:0] m, input logic [INDEX_W-1:0] ix,
                           input logic [VALUE_W-1:0] v, input logic [COUNT_W-1:0] c);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= m;
      req_index     <= ix;
      req_value     <= v;
      req_bit_count <= c;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop offering and wait until every owed result has been taken
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // APB write: setup phase, access phase, then idle with psel low
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] a, input logic [CSR_DATA_W-1:0] d);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= a;
      csr_pwdata  <= d;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_chain(input int len);
      csr_write(ADDR_CHAIN, len);
      chips_now = (len > CHIP_SLOTS) ? CHIP_SLOTS : len;
   endtask

   // mostly in-range commands so that the image actually gets exercised;
   // a slice of pure noise covers bad modes, indexes and counts
   task automatic send_random_cmd();
      int                 r;
      int                 pins;
      int                 lim;
      logic [MODE_W-1:0]  m;
      logic [INDEX_W-1:0] ix;
      logic [COUNT_W-1:0] c;
      pins = chips_now * 8;
      r    = $urandom_range(0, 99);
      if (r < 8 || pins == 0) begin
         m  = MODE_W'($urandom_range(0, 15));
         ix = INDEX_W'($urandom_range(0, 63));
         c  = COUNT_W'($urandom_range(0, 63));
      end else begin
         r = $urandom_range(0, 99);
         if (r < 3) m = MODE_INIT;
         else if (r < 15) m = MODE_SET_PIN;
         else if (r < 25) m = MODE_GET_PIN;
         else if (r < 33) m = MODE_TOGGLE;
         else if (r < 43) m = MODE_SET_CHIP;
         else if (r < 51) m = MODE_GET_CHIP;
         else if (r < 66) m = MODE_WRITE_RUN;
         else if (r < 80) m = MODE_READ_RUN;
         else if (r < 87) m = MODE_UPDATE;
         else if (r < 90) m = MODE_CLEAR;
         else if (r < 95) m = MODE_ENABLE;
         else m = MODE_DISABLE;
         if (m == MODE_SET_CHIP || m == MODE_GET_CHIP)
            ix = INDEX_W'($urandom_range(0, chips_now - 1));
         else
            ix = INDEX_W'($urandom_range(0, pins - 1));
         lim = pins - int'(ix);
         if (m == MODE_READ_RUN && lim > 32) lim = 32;
         if (lim > 63) lim = 63;
         c = COUNT_W'($urandom_range(0, lim));
      end
      send_cmd(m, ix, $urandom, c);
   endtask

   // chain length per random phase: both extremes of the register, zero and mid values
   function automatic int chain_for_phase(input int ph);
      case (ph)
         0:       return 8;
         1:       return 1;
         2:       return 5;
         3:       return 15;
         4:       return 2;
         5:       return 0;
         6:       return 8;
         7:       return 3;
         8:       return 4;
         default: return 8;
      endcase
   endfunction

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_mode      = MODE_INIT;
      req_index     = '0;
      req_value     = '0;
      req_bit_count = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      chips_now     = 1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: before init, with reset settings (one chip, no enable line) ---
      send_cmd(MODE_GET_PIN, '0, '0, '0);           // refused, not initialised
      send_cmd(MODE_TOP, '1, '1, '1);               // unknown mode, all field bits high
      send_cmd(MODE_BEYOND, '0, '0, '0);
      send_cmd(MODE_UPDATE, '0, '0, '0);            // refused, not initialised
      send_cmd(MODE_INIT, '0, '0, '0);

      // full chain with the enable line wired
      wait_idle();
      set_chain(8);
      csr_write(ADDR_OE, 1);
      send_cmd(MODE_INIT, '0, '0, '0);
      send_cmd(MODE_SET_PIN, 6'd63, 32'h0000_0001, '0);
      send_cmd(MODE_SET_PIN, 6'd0, 32'hFFFF_FFFE, '0);   // only bit0 counts
      send_cmd(MODE_GET_PIN, 6'd63, '0, '0);
      send_cmd(MODE_TOGGLE, 6'd5, '0, '0);
      send_cmd(MODE_SET_CHIP, 6'd7, 32'hFFFF_FFA5, '0);  // only the low byte counts
      send_cmd(MODE_GET_CHIP, 6'd7, '0, '0);
      send_cmd(MODE_SET_CHIP, 6'd8, '0, '0);             // chip past the chain
      send_cmd(MODE_WRITE_RUN, 6'd0, 32'hDEAD_BEEF, 6'd32);
      send_cmd(MODE_WRITE_RUN, 6'd16, '1, 6'd40);        // tail beyond 32 bits writes zeros
      send_cmd(MODE_READ_RUN, 6'd0, '0, 6'd32);
      send_cmd(MODE_READ_RUN, 6'd16, '0, 6'd33);         // read longer than 32 bits
      send_cmd(MODE_READ_RUN, 6'd63, '0, 6'd1);
      send_cmd(MODE_WRITE_RUN, 6'd63, '1, 6'd2);         // run off the end of the chain
      send_cmd(MODE_UPDATE, '0, '0, '0);
      send_cmd(MODE_DISABLE, '0, '0, '0);
      send_cmd(MODE_ENABLE, '0, '0, '0);
      send_cmd(MODE_CLEAR, '0, '0, '0);

      // shorter chain after init, enable line not wired
      wait_idle();
      set_chain(3);
      csr_write(ADDR_OE, 0);
      send_cmd(MODE_SET_PIN, 6'd24, 32'h1, '0);
      send_cmd(MODE_GET_CHIP, 6'd3, '0, '0);
      send_cmd(MODE_DISABLE, '0, '0, '0);                // ok, but the line stays put
      send_cmd(MODE_UPDATE, '0, '0, '0);

      // zero chips: pin access and init refused, an empty run accepted, update is a bare latch
      wait_idle();
      set_chain(0);
      send_cmd(MODE_UPDATE, '0, '0, '0);
      send_cmd(MODE_GET_PIN, '0, '0, '0);
      send_cmd(MODE_INIT, '0, '0, '0);
      send_cmd(MODE_WRITE_RUN, '0, '1, '0);

      // length above the maximum: init refused, update clamps to the full chain
      wait_idle();
      set_chain(15);
      send_cmd(MODE_INIT, '0, '0, '0);
      send_cmd(MODE_UPDATE, '0, '0, '0);

      // --- random phases, each under its own settings ---
      for (int ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         set_chain(chain_for_phase(ph));
         csr_write(ADDR_OE, ph % 2);
         burst = (ph == 2 || ph == 7);
         // long receiver hold-off on a full chain: queue fills and req_ready drops
         if (ph == 3) rsp_hold = 1'b1;
         send_cmd(MODE_INIT, INDEX_W'($urandom), $urandom, COUNT_W'($urandom));
         for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
            // sender pauses mid-phase until the block has drained
            if (ph == 6 && k == RANDOM_PER_PHASE / 2) wait_idle();
            send_random_cmd();
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/srox_pkg.sv
hdl/srox_front.sv
hdl/srox_queue.sv
hdl/srox_back.sv
hdl/shift_register_output_expander_top.sv
hdl/srox_checker.sv
bench/srox_shadow_checker.sv
bench/shift_register_output_expander_top_tb.sv
